// File: hw/rtl/gbts_pkg.sv
// Shared types and constants for the gap buffer text store.
`timescale 1ns / 1ps
package gbts_pkg;
   localparam int Capacity = 4096;
   localparam int AddrW = $clog2(Capacity);
   localparam int CountW = AddrW + 1;
   localparam logic [7:0] NewlineByte = 8'h0A;
   localparam logic [7:0] WrapReset = 8'd80;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0, OP_BACKSPACE = 3'd1, OP_LEFT = 3'd2, OP_RIGHT = 3'd3,
      OP_MOVE = 3'd4, OP_UP = 3'd5, OP_DOWN = 3'd6, OP_READ = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_FULL = 2'd1, ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_SEARCH_WAIT, S_SHIFT_RD, S_SHIFT_WR,
      S_READ_WAIT, S_COUNT_START, S_COUNT, S_RESP
   } state_type;
endpackage

// File: hw/rtl/gap_buffer_text_store_core.sv
// Top level of the gap buffer text store: command sequencer around one RAM.
//
// Channels: commands enter on req_ (op, char_value, target_index) with
// valid/ready; each command yields exactly one transfer on rsp_ with the
// cursor row and column, text length, cursor position, char_out and status.
// The csr_ port writes wrap_columns (reset 80) whenever csr_we is high.
// One command is in work at a time. Insert and backspace go straight to
// the recount; left/right/move first shift the gap, a read and a write per
// byte moved; up/down first search byte by byte for a newline, then shift
// the gap to it; read first waits for the RAM data. The row/column recount
// reads the text before the cursor one byte per cycle from the single RAM
// port. Reset empties the text at once; the RAM holds no reset. While rsp_
// is stalled the result register holds and req_ready stays low until the
// transfer completes.
`timescale 1ns / 1ps
module gap_buffer_text_store_core
   import gbts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_char_value,
   input  logic [12:0] req_target_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_cursor_row,
   output logic [7:0]  rsp_cursor_col,
   output logic [12:0] rsp_text_length,
   output logic [12:0] rsp_cursor_position,
   output logic [7:0]  rsp_char_out,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   state_type state_ff, state_in;
   logic [CountW-1:0] before_ff, before_in, after_ff, after_in;
   logic [CountW-1:0] dest_ff, dest_in;       // target before_count for gap moves
   logic [CountW-1:0] idx_ff, idx_in;         // walk index for search and recount
   logic [12:0] row_ff, row_in;
   logic [7:0]  col_ff, col_in, wrap_ff;
   logic [7:0]  char_ff, char_in;
   status_type  status_ff, status_in;
   op_type      op_ff, op_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic             ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [7:0]       ram_wdata, ram_rdata;
   logic [CountW-1:0] length;
   logic [CountW-1:0] tgt;

   gbts_ram #(.Width(8), .Depth(Capacity)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   assign length = before_ff + after_ff;
   assign tgt = req_target_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         before_ff <= '0;
         after_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wrap_ff <= WrapReset;
      end else begin
         state_ff <= state_in;
         before_ff <= before_in;
         after_ff <= after_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            wrap_ff <= csr_wdata;
         end
      end
      dest_ff <= dest_in;
      idx_ff <= idx_in;
      row_ff <= row_in;
      col_ff <= col_in;
      char_ff <= char_in;
      status_ff <= status_in;
      op_ff <= op_in;
   end

   always_comb begin
      state_in = state_ff;
      before_in = before_ff;
      after_in = after_ff;
      dest_in = dest_ff;
      idx_in = idx_ff;
      row_in = row_ff;
      col_in = col_ff;
      char_in = char_ff;
      status_in = status_ff;
      op_in = op_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;
      ram_addr = before_ff[AddrW-1:0];
      ram_wdata = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = op_type'(req_op);
               status_in = ST_DONE;
               char_in = '0;
               dest_in = before_ff;
               state_in = S_SHIFT_RD;
               case (op_type'(req_op))
                  OP_INSERT: begin
                     state_in = S_COUNT_START;
                     if (length >= CountW'(Capacity)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we = 1'b1;
                        ram_wdata = req_char_value;
                        before_in = before_ff + 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     state_in = S_COUNT_START;
                     if (before_ff != '0) before_in = before_ff - 1'b1;
                     else status_in = ST_RANGE;
                  end
                  OP_LEFT: begin
                     if (before_ff != '0) dest_in = before_ff - 1'b1;
                     else status_in = ST_RANGE;
                  end
                  OP_RIGHT: begin
                     if (after_ff != '0) dest_in = before_ff + 1'b1;
                     else status_in = ST_RANGE;
                  end
                  OP_MOVE: begin
                     if (tgt > length) status_in = ST_RANGE;
                     else dest_in = tgt;
                  end
                  OP_UP: begin
                     // walk back from the byte before the cursor
                     idx_in = before_ff;
                     state_in = S_SEARCH;
                  end
                  OP_DOWN: begin
                     idx_in = '0;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_COUNT_START;
                     if (tgt >= length) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_READ_WAIT;
                        if (tgt < before_ff) ram_addr = tgt[AddrW-1:0];
                        else ram_addr = AddrW'(tgt - before_ff - after_ff);
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // issue one read; for down idx counts bytes searched, for up it walks back
            if (op_ff == OP_UP) begin
               if (idx_ff == '0) begin
                  status_in = ST_RANGE;
                  state_in = S_COUNT_START;
               end else begin
                  ram_addr = AddrW'(idx_ff - 1'b1);
                  state_in = S_SEARCH_WAIT;
               end
            end else begin
               if (idx_ff >= after_ff) begin
                  status_in = ST_RANGE;
                  state_in = S_COUNT_START;
               end else begin
                  ram_addr = AddrW'(idx_ff - after_ff);
                  state_in = S_SEARCH_WAIT;
               end
            end
         end
         S_SEARCH_WAIT: begin
            state_in = S_SEARCH;
            if (op_ff == OP_UP) begin
               idx_in = idx_ff - 1'b1;
               if (ram_rdata == NewlineByte) begin
                  dest_in = idx_ff - 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               if (ram_rdata == NewlineByte) begin
                  dest_in = before_ff + idx_ff + 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            // read the byte that crosses the gap next
            if (before_ff > dest_ff) begin
               ram_addr = AddrW'(before_ff - 1'b1);
               state_in = S_SHIFT_WR;
            end else if (before_ff < dest_ff) begin
               ram_addr = AddrW'(CountW'(0) - after_ff);
               state_in = S_SHIFT_WR;
            end else begin
               state_in = S_COUNT_START;
            end
         end
         S_SHIFT_WR: begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata;
            state_in = S_SHIFT_RD;
            if (before_ff > dest_ff) begin
               ram_addr = AddrW'(CountW'(0) - after_ff - 1'b1);
               before_in = before_ff - 1'b1;
               after_in = after_ff + 1'b1;
            end else begin
               ram_addr = before_ff[AddrW-1:0];
               before_in = before_ff + 1'b1;
               after_in = after_ff - 1'b1;
            end
         end
         S_READ_WAIT: begin
            char_in = ram_rdata;
            state_in = S_COUNT_START;
         end
         S_COUNT_START: begin
            row_in = '0;
            col_in = '0;
            idx_in = '0;
            state_in = S_RESP;
            if (before_ff != '0) begin
               ram_addr = '0;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            // ram_rdata is byte idx; issue read of idx+1
            ram_addr = AddrW'(idx_ff + 1'b1);
            idx_in = idx_ff + 1'b1;
            if (ram_rdata == NewlineByte || col_ff + 9'd1 >= {1'b0, wrap_ff}) begin
               row_in = row_ff + 1'b1;
               col_in = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (idx_ff + 1'b1 == before_ff) state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_text_length = length;
   assign rsp_cursor_position = before_ff;
   assign rsp_char_out = char_ff;
   assign rsp_status = status_ff;

   // A result is only offered from the response state.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP) else $error("rsp_valid outside response");
   // The text never exceeds capacity.
   a_cap: assert property (@(posedge clock) disable iff (reset)
      length <= CountW'(Capacity)) else $error("length over capacity");
   // No command is accepted while a result is pending.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready with result pending");
endmodule

// File: hw/rtl/gbts_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module gbts_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule
